### design/deadline_oneshot_rearm_unit_macros.svh
// Assertion macros shared by the deadline timer modules
`ifndef DEADLINE_ONESHOT_REARM_UNIT_MACROS_SVH
`define DEADLINE_ONESHOT_REARM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, disabled while i_rst_n is low
`define DOR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, disabled while i_rst_n is low
`define DOR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dor_pkg.sv
`timescale 1ns / 1ps
// Package: constants, derived widths and types of the deadline timer
package dor_pkg;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned COUNT_W    = 16;

    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd1;
    localparam logic [OP_W-1:0] OP_FIRE   = 2'd2;

    localparam longint unsigned INPUT_CLOCK_HZ = 64'd1193182;
    localparam longint unsigned MAX_COUNT      = 64'd65535;
    localparam longint unsigned SPAN_CAP_NS    = 64'd54925450;
    localparam longint unsigned NS_PER_S       = 64'd1000000000;

    // Reciprocal scaling: count ~ (span * RECIP_MUL) >> RECIP_SHIFT, never above the true value
    localparam int unsigned     RECIP_SHIFT = 32;
    localparam longint unsigned RECIP_MUL   = (INPUT_CLOCK_HZ << RECIP_SHIFT) / NS_PER_S;

    localparam int unsigned SPAN_W    = $clog2(SPAN_CAP_NS + 64'd1);
    localparam int unsigned HZ_W      = $clog2(INPUT_CLOCK_HZ + 64'd1);
    localparam int unsigned NS_W      = $clog2(NS_PER_S + 64'd1);
    localparam int unsigned RECIP_W   = $clog2(RECIP_MUL + 64'd1);
    localparam int unsigned PROD_W    = SPAN_W + RECIP_W;
    localparam int unsigned Q_W       = PROD_W - RECIP_SHIFT;
    localparam int unsigned HZ_PROD_W = SPAN_W + HZ_W;
    localparam int unsigned T_W       = Q_W + 1 + NS_W;
    localparam int unsigned CMP_W     = ((T_W > HZ_PROD_W) ? T_W : HZ_PROD_W) + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_COUNT);
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // What the result carries once the request has been decoded
    typedef enum logic [1:0] {
        KIND_NONE,   // no reload
        KIND_SPAN,   // reload with the scaled span
        KIND_ONE,    // deadline already passed: reload with one
        KIND_PARK    // disarm: park at the maximum count
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  deliver;
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [SPAN_W-1:0] span;
    } t_s1;

endpackage

### design/dor_req_if.sv
`timescale 1ns / 1ps
// Interface: request channel of the deadline timer
interface dor_req_if;
    logic                            valid;
    logic                            ready;
    logic [dor_pkg::OP_W-1:0]        operation;
    logic [dor_pkg::TIME_W-1:0]      due_ns;
    logic [dor_pkg::TIME_W-1:0]      now_ns;

    modport source (output valid, operation, due_ns, now_ns, input ready);
    modport sink   (input valid, operation, due_ns, now_ns, output ready);
endinterface

### design/dor_rsp_if.sv
`timescale 1ns / 1ps
// Interface: result channel of the deadline timer
interface dor_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            program_valid;
    logic [dor_pkg::COUNT_W-1:0]     program_count;
    logic                            deliver_expiry;

    modport source (output valid, program_valid, program_count, deliver_expiry, input ready);
    modport sink   (input valid, program_valid, program_count, deliver_expiry, output ready);
endinterface

### design/dor_front.sv
`timescale 1ns / 1ps
// Module: request register, armed/target state and span decision
`include "deadline_oneshot_rearm_unit_macros.svh"
module dor_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_callback,
    dor_req_if.sink              i_req,
    output logic                 o_s1_valid,
    output dor_pkg::t_s1         o_s1,
    input  logic                 i_s1_ready
);

    logic                           r_v0;
    logic [dor_pkg::OP_W-1:0]       r_op;
    logic [dor_pkg::TIME_W-1:0]     r_deadline;
    logic [dor_pkg::TIME_W-1:0]     r_now;

    logic                           r_armed;
    logic                           n_armed;
    logic [dor_pkg::TIME_W-1:0]     r_target;
    logic [dor_pkg::TIME_W-1:0]     n_target;

    logic                           r_v1;
    dor_pkg::t_s1                   r_s1;
    dor_pkg::t_s1                   n_s1;

    logic                           en0;
    logic                           en1;
    logic                           adv1;
    logic [dor_pkg::TIME_W-1:0]     cmp_tgt;
    logic [dor_pkg::TIME_W-1:0]     diff;
    logic                           borrow;
    logic                           ahead;
    logic [dor_pkg::SPAN_W-1:0]     span_cl;

    assign en1         = !r_v1 || i_s1_ready;
    assign en0         = !r_v0 || en1;
    assign adv1        = r_v0 && en1;
    assign i_req.ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en0) begin
            r_v0 <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_req.valid) begin
            r_op       <= i_req.operation;
            r_deadline <= i_req.due_ns;
            r_now      <= i_req.now_ns;
        end
    end

    // One subtractor serves both the ahead test and the span
    assign cmp_tgt        = (r_op == dor_pkg::OP_ARM) ? r_deadline : r_target;
    assign {borrow, diff} = {1'b0, cmp_tgt} - {1'b0, r_now};
    assign ahead          = !borrow && (diff != '0);
    assign span_cl        = (diff > dor_pkg::SPAN_CAP_NS) ?
                            dor_pkg::SPAN_W'(dor_pkg::SPAN_CAP_NS) :
                            diff[dor_pkg::SPAN_W-1:0];

    always_comb begin
        n_armed         = r_armed;
        n_target        = r_target;
        n_s1.tag.kind    = dor_pkg::KIND_NONE;
        n_s1.tag.deliver = 1'b0;
        n_s1.span        = span_cl;
        unique case (r_op)
            dor_pkg::OP_ARM: begin
                n_target      = r_deadline;
                n_armed       = 1'b1;
                n_s1.tag.kind = ahead ? dor_pkg::KIND_SPAN : dor_pkg::KIND_ONE;
            end
            dor_pkg::OP_DISARM: begin
                n_armed       = 1'b0;
                n_target      = '0;
                n_s1.tag.kind = dor_pkg::KIND_PARK;
            end
            dor_pkg::OP_FIRE: begin
                if (r_armed) begin
                    if (ahead) begin
                        n_s1.tag.kind = dor_pkg::KIND_SPAN;
                    end else begin
                        n_armed          = 1'b0;
                        n_s1.tag.deliver = i_callback;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= 1'b0;
            r_target <= '0;
            r_v1     <= 1'b0;
        end else begin
            if (adv1) begin
                r_armed  <= n_armed;
                r_target <= n_target;
            end
            if (en1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_v1;
    assign o_s1       = r_s1;

    `DOR_ASSERT_IMPL(a_span_range, r_v1 && r_s1.tag.kind == dor_pkg::KIND_SPAN, r_s1.span != '0 && r_s1.span <= dor_pkg::SPAN_W'(dor_pkg::SPAN_CAP_NS), "span out of range")
    `DOR_ASSERT_NEXT(a_arm_sets, adv1 && r_op == dor_pkg::OP_ARM, r_armed, "arm left block idle")
    `DOR_ASSERT_NEXT(a_expire_clears, adv1 && r_op == dor_pkg::OP_FIRE && !ahead, !r_armed, "expiry left block armed")

endmodule

### design/dor_scale.sv
`timescale 1ns / 1ps
// Module: span-to-count scaling pipeline and result register
`include "deadline_oneshot_rearm_unit_macros.svh"
module dor_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s1_valid,
    input  dor_pkg::t_s1         i_s1,
    output logic                 o_s1_ready,
    dor_rsp_if.source            o_rsp
);

    logic                              r_v2;
    dor_pkg::t_tag                     r_tag2;
    logic [dor_pkg::PROD_W-1:0]        r_prod2;
    logic [dor_pkg::HZ_PROD_W-1:0]     r_hz2;

    logic                              r_v3;
    dor_pkg::t_tag                     r_tag3;
    logic [dor_pkg::Q_W-1:0]           r_q3;
    logic [dor_pkg::T_W-1:0]           r_t3;
    logic [dor_pkg::HZ_PROD_W-1:0]     r_hz3;

    logic                              r_vo;
    logic                              r_pv;
    logic [dor_pkg::COUNT_W-1:0]       r_cnt;
    logic                              r_dlv;

    logic                              en2;
    logic                              en3;
    logic                              en_o;
    logic [dor_pkg::Q_W-1:0]           q0;
    logic                              ge;
    logic [dor_pkg::Q_W:0]             q_fix;
    logic [dor_pkg::COUNT_W-1:0]       span_cnt;
    logic                              n_pv;
    logic [dor_pkg::COUNT_W-1:0]       n_cnt;

    assign en_o       = !r_vo || o_rsp.ready;
    assign en3        = !r_v3 || en_o;
    assign en2        = !r_v2 || en3;
    assign o_s1_ready = en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_s1_valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en_o) begin
                r_vo <= r_v3;
            end
        end
    end

    // Two independent products: reciprocal estimate and exact numerator
    always_ff @(posedge i_clk) begin
        if (en2 && i_s1_valid) begin
            r_tag2  <= i_s1.tag;
            r_prod2 <= dor_pkg::PROD_W'(i_s1.span) * dor_pkg::PROD_W'(dor_pkg::RECIP_MUL);
            r_hz2   <= dor_pkg::HZ_PROD_W'(i_s1.span)
                       * dor_pkg::HZ_PROD_W'(dor_pkg::INPUT_CLOCK_HZ);
        end
    end

    assign q0 = r_prod2[dor_pkg::PROD_W-1:dor_pkg::RECIP_SHIFT];

    // Check value for the one-step upward correction
    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_tag3 <= r_tag2;
            r_q3   <= q0;
            r_hz3  <= r_hz2;
            r_t3   <= dor_pkg::T_W'({1'b0, q0} + (dor_pkg::Q_W + 1)'(1))
                      * dor_pkg::T_W'(dor_pkg::NS_PER_S);
        end
    end

    assign ge    = dor_pkg::CMP_W'(r_t3) <= dor_pkg::CMP_W'(r_hz3);
    assign q_fix = ge ? ({1'b0, r_q3} + (dor_pkg::Q_W + 1)'(1)) : {1'b0, r_q3};

    always_comb begin
        if (q_fix == '0) begin
            span_cnt = dor_pkg::COUNT_ONE;
        end else if (q_fix > (dor_pkg::Q_W + 1)'(dor_pkg::MAX_COUNT)) begin
            span_cnt = dor_pkg::COUNT_MAX;
        end else begin
            span_cnt = q_fix[dor_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        n_pv  = 1'b1;
        n_cnt = '0;
        unique case (r_tag3.kind)
            dor_pkg::KIND_SPAN: n_cnt = span_cnt;
            dor_pkg::KIND_ONE:  n_cnt = dor_pkg::COUNT_ONE;
            dor_pkg::KIND_PARK: n_cnt = dor_pkg::COUNT_MAX;
            default:            n_pv  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_o && r_v3) begin
            r_pv  <= n_pv;
            r_cnt <= n_cnt;
            r_dlv <= r_tag3.deliver;
        end
    end

    assign o_rsp.valid          = r_vo;
    assign o_rsp.program_valid  = r_pv;
    assign o_rsp.program_count  = r_cnt;
    assign o_rsp.deliver_expiry = r_dlv;

    `DOR_ASSERT_IMPL(a_est_not_high, r_v3 && r_tag3.kind == dor_pkg::KIND_SPAN, dor_pkg::CMP_W'(r_t3) <= dor_pkg::CMP_W'(r_hz3) + dor_pkg::CMP_W'(dor_pkg::NS_PER_S), "estimate above quotient")
    `DOR_ASSERT_IMPL(a_est_not_low, r_v3 && r_tag3.kind == dor_pkg::KIND_SPAN, dor_pkg::CMP_W'(r_t3) + dor_pkg::CMP_W'(dor_pkg::NS_PER_S) > dor_pkg::CMP_W'(r_hz3), "estimate short by more than one")
    `DOR_ASSERT_IMPL(a_idle_count_zero, r_vo && !r_pv, r_cnt == '0, "count without reload")
    `DOR_ASSERT_IMPL(a_deliver_alone, r_vo && r_dlv, !r_pv, "delivery alongside reload")

endmodule

### design/deadline_oneshot_rearm_unit.sv
`timescale 1ns / 1ps
// Top level: one-shot nanosecond deadline timer with rearm over a 16-bit counter
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+----------------------------------------------
//  i_req     | in  | valid / ready | operation[1:0], due_ns[63:0], now_ns[63:0]
//  o_rsp     | out | valid / ready | program_valid, program_count[15:0], deliver_expiry
//  i_cfg_*   | in  | write enable  | i_cfg_wdata = callback_present
//
//  Throughput: one request per cycle while no stage is stalled; every request yields
//  exactly one result. Pipeline: request, decision, two multiplier and result registers;
//  armed and target update in the decision stage.
//  Reset (i_rst_n low, synchronous): idle, not armed, target zero, callback off.
//  Stalls: each stage holds while the one after it is full and stalled; a request is
//  still taken while a finished result waits, as long as some stage has room.
module deadline_oneshot_rearm_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    dor_req_if.sink     i_req,
    dor_rsp_if.source   o_rsp
);

    // Callback-present register: gates the expiry report only
    logic r_callback;

    // Decision stage to scaling pipeline
    logic         s1_valid;
    logic         s1_ready;
    dor_pkg::t_s1 s1;

    // Callback setting; the user writes it only while the block is quiet, unenforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_callback <= 1'b0;
        end else if (i_cfg_we) begin
            r_callback <= i_cfg_wdata;
        end
    end

    // Register the request, decode arm / disarm / fire against the armed state,
    // and clamp the remaining span
    dor_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_callback (r_callback),
        .i_req      (i_req),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .i_s1_ready (s1_ready)
    );

    // Scale the span to counter ticks (reciprocal estimate plus one-step
    // correction), saturate, and drive the result register
    dor_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s1_ready (s1_ready),
        .o_rsp      (o_rsp)
    );

endmodule

### tb/tb_deadline_oneshot_rearm_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench: deadline timer requests against an in-bench timer model
module tb_deadline_oneshot_rearm_unit;

    // Timer constants kept locally so the package values get checked too
    localparam logic [63:0] TICK_HZ     = 64'd1193182;
    localparam logic [63:0] CAP_NS      = 64'd54925450;
    localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;
    localparam logic [63:0] COUNT_CEIL  = 64'd65535;
    localparam logic [15:0] PARK_COUNT  = 16'hFFFF;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    // Pipeline depth from the top-level header, plus margin for settling
    localparam int LATENCY      = 5;
    localparam int SETTLE       = 2 * LATENCY + 2;
    localparam int WATCHDOG_MAX = 2000;
    localparam int PHASE_ITEMS  = 195;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] deadline;
        logic [63:0] now;
    } t_timer_req;

    typedef struct packed {
        logic        program_valid;
        logic [15:0] program_count;
        logic        deliver_expiry;
    } t_timer_rsp;

    // One row of the directed table; cfg < 0 leaves callback_present alone
    typedef struct {
        int         cfg;
        t_timer_req req;
        bit         typed;
        t_timer_rsp want;
    } t_directed_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    dor_req_if req_ch ();
    dor_rsp_if rsp_ch ();

    deadline_oneshot_rearm_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    // Timer model state, mirrors the block's armed flag, target and register
    logic        timer_armed;
    logic [63:0] timer_target;
    logic        callback_on;

    t_timer_rsp    pending_results[$];
    t_directed_row directed_rows[$];

    int mismatch_count;
    int results_checked;
    int expiries_seen;
    int rearms_predicted;
    int counted_requests;
    int op_seen[4];
    int cfg_writes[2];
    int idle_cycles;

    bit tx_steady;
    bit rx_steady;
    int rx_hold;

    logic [63:0] wall_ns;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reload count for the time left until target, as the 16-bit counter takes it
    function automatic logic [15:0] ticks_for_span(logic [63:0] target, logic [63:0] now);
        logic [63:0] span;
        logic [63:0] ticks;
        if (target <= now)
            return 16'd1;
        span = target - now;
        if (span > CAP_NS)
            span = CAP_NS;
        ticks = (span * TICK_HZ) / NS_PER_SEC;
        if (ticks == 64'd0)
            ticks = 64'd1;
        if (ticks > COUNT_CEIL)
            ticks = COUNT_CEIL;
        return ticks[15:0];
    endfunction

    // Advance the timer model by one request and return the result it yields
    function automatic t_timer_rsp step_timer_model(t_timer_req r);
        t_timer_rsp res;
        res = '0;
        case (r.op)
            dor_pkg::OP_ARM: begin
                timer_target      = r.deadline;
                timer_armed       = 1'b1;
                res.program_valid = 1'b1;
                res.program_count = ticks_for_span(r.deadline, r.now);
            end
            dor_pkg::OP_DISARM: begin
                timer_armed       = 1'b0;
                timer_target      = '0;
                res.program_valid = 1'b1;
                res.program_count = PARK_COUNT;
            end
            dor_pkg::OP_FIRE: begin
                if (timer_armed) begin
                    if (timer_target > r.now) begin
                        res.program_valid = 1'b1;
                        res.program_count = ticks_for_span(timer_target, r.now);
                        rearms_predicted++;
                    end else begin
                        timer_armed        = 1'b0;
                        res.deliver_expiry = callback_on;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short gaps, a few long ones, none at all during steady stretches
    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH on result %0d, %s: got %0h, expected %0h",
                     results_checked, field, got, want);
    endtask

    task automatic add_row(int cfg, logic [1:0] op, logic [63:0] deadline, logic [63:0] now,
                           bit typed, logic pv, logic [15:0] pc, logic de);
        t_directed_row row;
        row.cfg       = cfg;
        row.req       = '{op: op, deadline: deadline, now: now};
        row.typed     = typed;
        row.want      = '{program_valid: pv, program_count: pc, deliver_expiry: de};
        directed_rows.push_back(row);
    endtask

    // Present one request and hold it until the block takes it; valid stays high
    // afterwards so a back-to-back request needs no second assignment in the step
    task automatic send_request(t_timer_req r, bit typed, t_timer_rsp want);
        int         gap;
        t_timer_rsp predicted;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= r.op;
        req_ch.due_ns    <= r.deadline;
        req_ch.now_ns    <= r.now;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predicted = step_timer_model(r);
        pending_results.push_back(typed ? want : predicted);
        op_seen[r.op]++;
        counted_requests++;
    endtask

    task automatic issue(logic [1:0] op, logic [63:0] deadline, logic [63:0] now);
        send_request('{op: op, deadline: deadline, now: now}, 1'b0, '0);
    endtask

    // Drop valid and hold off until every outstanding result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Only ever called with the block drained
    task automatic write_callback(logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        callback_on  = value;
        cfg_writes[value]++;
    endtask

    // One random episode: mostly an arm followed by fires walking time forward
    // until expiry, with disarms, stray fires and unused codes mixed in
    task automatic play_episode();
        int          pick;
        int          fires;
        logic [63:0] span;
        logic [63:0] deadline;
        logic [63:0] step;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            wall_ns = rand64();
        if (pick < 62) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                span = 64'($urandom_range(0, 3000));
            else if (pick < 60)
                span = 64'($urandom_range(3001, 60_000_000));
            else if (pick < 80)
                span = 64'($urandom_range(60_000_000, 400_000_000));
            else
                span = '0;
            if (pick < 80)
                deadline = wall_ns + span;
            else if (pick < 90)
                deadline = wall_ns - 64'($urandom_range(0, 5000));
            else
                deadline = rand64();
            issue(dor_pkg::OP_ARM, deadline, wall_ns);
            fires = $urandom_range(1, 6);
            for (int i = 0; i < fires; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    issue(dor_pkg::OP_DISARM, rand64(), rand64());
                    issue(dor_pkg::OP_FIRE, rand64(), wall_ns);
                    return;
                end
                if (span > 64'd0 && span < 64'd500_000_000)
                    step = 64'($urandom_range(0, span[31:0] / 2 + 1));
                else
                    step = 64'($urandom_range(0, 500_000_000));
                wall_ns = wall_ns + step;
                if (i == fires - 1 && $urandom_range(0, 4) != 0)
                    wall_ns = deadline + 64'($urandom_range(0, 1000));
                issue(dor_pkg::OP_FIRE, rand64(), wall_ns);
            end
            if ($urandom_range(0, 4) == 0)
                issue(dor_pkg::OP_FIRE, rand64(), wall_ns);
        end else if (pick < 72) begin
            issue(dor_pkg::OP_ARM, rand64(), rand64());
            issue(dor_pkg::OP_FIRE, rand64(), rand64());
        end else if (pick < 82) begin
            issue(dor_pkg::OP_DISARM, rand64(), rand64());
        end else if (pick < 90) begin
            issue(OP_UNUSED, rand64(), rand64());
        end else begin
            issue(dor_pkg::OP_FIRE, rand64(),
                  ($urandom_range(0, 1) == 1) ? wall_ns : rand64());
        end
    endtask

    // Result side: random stalls, mostly short, a few long, steady stretches between
    always @(posedge clk) begin
        int r;
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            r = $urandom_range(0, 99);
            if (rx_steady) begin
                rsp_ch.ready <= 1'b1;
                rx_hold       = 20;
            end else if (r < 65) begin
                rsp_ch.ready <= 1'b1;
                rx_hold       = $urandom_range(0, 4);
            end else if (r < 93) begin
                rsp_ch.ready <= 1'b0;
                rx_hold       = $urandom_range(0, 3);
            end else begin
                rsp_ch.ready <= 1'b0;
                rx_hold       = $urandom_range(10, 40);
            end
        end
    end

    // Check each accepted result against the oldest outstanding expectation
    always @(posedge clk) begin
        t_timer_rsp want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_checked++;
            if (rsp_ch.deliver_expiry === 1'b1)
                expiries_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", {46'd0, rsp_ch.program_valid,
                                rsp_ch.program_count, rsp_ch.deliver_expiry}, '0);
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.program_valid !== want.program_valid)
                    report_mismatch("program_valid", 64'(rsp_ch.program_valid),
                                    64'(want.program_valid));
                if (rsp_ch.program_count !== want.program_count)
                    report_mismatch("program_count", 64'(rsp_ch.program_count),
                                    64'(want.program_count));
                if (rsp_ch.deliver_expiry !== want.deliver_expiry)
                    report_mismatch("deliver_expiry", 64'(rsp_ch.deliver_expiry),
                                    64'(want.deliver_expiry));
            end
        end
    end

    // Watchdog: count cycles in which neither side moves anything
    always @(posedge clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [63:0] ones;
        logic [63:0] t0;
        logic        phase_cfg[4];

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = '0;
        req_ch.due_ns    = '0;
        req_ch.now_ns    = '0;
        timer_armed      = 1'b0;
        timer_target     = '0;
        callback_on      = 1'b0;
        tx_steady        = 1'b0;
        ones             = '1;
        t0               = 64'd4_000_000_000;

        // Directed table. Typed rows hold the answer; the rest go to the model.
        add_row(-1, dor_pkg::OP_FIRE,   '0, '0, 1'b1, 1'b0, 16'd0, 1'b0);     // fire while idle
        add_row(-1, OP_UNUSED, ones, ones, 1'b1, 1'b0, 16'd0, 1'b0);          // unused code
        add_row(-1, dor_pkg::OP_DISARM, ones, ones, 1'b1, 1'b1, PARK_COUNT, 1'b0); // disarm idle
        add_row(-1, dor_pkg::OP_ARM,    '0, '0, 1'b1, 1'b1, 16'd1, 1'b0);     // deadline is now
        add_row(-1, dor_pkg::OP_FIRE,   '0, '0, 1'b1, 1'b0, 16'd0, 1'b0);     // expiry, silent
        add_row( 1, dor_pkg::OP_ARM,    64'd100, 64'd200, 1'b1, 1'b1, 16'd1, 1'b0); // passed
        add_row(-1, dor_pkg::OP_FIRE,   '0, 64'd300, 1'b1, 1'b0, 16'd0, 1'b1); // then delivers
        add_row(-1, dor_pkg::OP_FIRE,   '0, 64'd300, 1'b1, 1'b0, 16'd0, 1'b0); // idle again
        add_row(-1, dor_pkg::OP_ARM,    ones, '0, 1'b1, 1'b1, PARK_COUNT, 1'b0); // far past cap
        add_row(-1, dor_pkg::OP_FIRE,   '0, '0, 1'b1, 1'b1, PARK_COUNT, 1'b0); // rearm at cap
        add_row(-1, dor_pkg::OP_FIRE,   '0, ones, 1'b1, 1'b0, 16'd0, 1'b1);   // now at maximum
        add_row(-1, dor_pkg::OP_ARM,    64'd500, '0, 1'b1, 1'b1, 16'd1, 1'b0); // scales to zero
        add_row(-1, dor_pkg::OP_FIRE,   ones, 64'd499, 1'b1, 1'b1, 16'd1, 1'b0); // one ns left
        add_row(-1, dor_pkg::OP_DISARM, '0, '0, 1'b1, 1'b1, PARK_COUNT, 1'b0); // disarm armed
        add_row(-1, dor_pkg::OP_FIRE,   '0, '0, 1'b1, 1'b0, 16'd0, 1'b0);     // after disarm
        add_row(-1, dor_pkg::OP_ARM,    64'd12345 + CAP_NS, 64'd12345, 1'b0, 1'b0, 16'd0, 1'b0);
        add_row(-1, dor_pkg::OP_FIRE,   '0, 64'd12346, 1'b0, 1'b0, 16'd0, 1'b0);
        add_row(-1, dor_pkg::OP_ARM,    t0 + 64'd1_000_000, t0, 1'b0, 1'b0, 16'd0, 1'b0);
        add_row(-1, dor_pkg::OP_ARM,    ones, ones, 1'b1, 1'b1, 16'd1, 1'b0); // both maximum
        add_row(-1, dor_pkg::OP_ARM,    64'd5_000_000_000, t0, 1'b0, 1'b0, 16'd0, 1'b0);
        add_row(-1, dor_pkg::OP_FIRE,   '0, 64'd5_000_000_000, 1'b1, 1'b0, 16'd0, 1'b1);
        add_row( 0, dor_pkg::OP_ARM,    64'd10, '0, 1'b1, 1'b1, 16'd1, 1'b0);
        add_row(-1, OP_UNUSED, ones, ones, 1'b1, 1'b0, 16'd0, 1'b0);          // unused, armed
        add_row(-1, dor_pkg::OP_FIRE,   '0, 64'd10, 1'b1, 1'b0, 16'd0, 1'b0); // silent expiry
        add_row(-1, dor_pkg::OP_ARM,    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                1'b1, 1'b1, 16'd1, 1'b0);                                     // carry at bit 63

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg >= 0) begin
                drain_results();
                write_callback(directed_rows[i].cfg[0]);
            end
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].want);
        end

        // Random phases, each under its own callback setting
        phase_cfg[0] = 1'b1;
        phase_cfg[1] = 1'b0;
        phase_cfg[2] = 1'b1;
        phase_cfg[3] = 1'($urandom_range(0, 1));
        wall_ns      = rand64();
        for (int p = 0; p < 4; p++) begin
            drain_results();
            write_callback(phase_cfg[p]);
            counted_requests = 0;
            while (counted_requests < PHASE_ITEMS) begin
                if ($urandom_range(0, 29) == 0)
                    tx_steady = !tx_steady;
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                play_episode();
            end
        end

        drain_results();

        $display("Covered %0d arm, %0d disarm, %0d fire and %0d unused requests,",
                 op_seen[dor_pkg::OP_ARM], op_seen[dor_pkg::OP_DISARM],
                 op_seen[dor_pkg::OP_FIRE], op_seen[OP_UNUSED]);
        $display("with callback off %0d and on %0d times: %0d results, %0d rearms, %0d expiries",
                 cfg_writes[0], cfg_writes[1], results_checked, rearms_predicted,
                 expiries_seen);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
